/* sv/ptd_pkg.sv */
// ============================================================================
// ptd_pkg
// Shared types and codes of the periodic task dispatch table.
// ============================================================================
`default_nettype none

package ptd_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_CREATE     = 3'd0;
    localparam logic [2:0] REQ_SET_STATUS = 3'd1;
    localparam logic [2:0] REQ_GET_STATUS = 3'd2;
    localparam logic [2:0] REQ_SET_TIMERS = 3'd3;
    localparam logic [2:0] REQ_SCAN       = 3'd4;

    // Task status codes.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_UNDEF   = 2'd3;

    // One request item.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  task_id;
        logic [31:0] start_time;
        logic [31:0] period;
        logic        periodic;
        logic [1:0]  new_status;
        logic [31:0] now_time;
    } ptd_in_t;

    // One result item.
    typedef struct packed {
        logic [3:0] result_id;
        logic [1:0] status;
        logic       fired;
        logic       last;
    } ptd_out_t;

endpackage

`default_nettype wire

/* sv/ptd_table.sv */
// ============================================================================
// ptd_table
// Task entry memory: one write port, one registered read port, and a valid
// bit per entry, registered into rd_vld, that marks entries never written.
// ============================================================================
`default_nettype none

module ptd_table #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 67
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    output logic               rd_vld,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits are cleared all at once by reset; the memory itself is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_vld  = rd_vld_reg;

endmodule

`default_nettype wire

/* sv/periodic_task_dispatch_table_unit.sv */
// ============================================================================
// periodic_task_dispatch_table_unit
// Table of periodic and run-once tasks with create, status, timer and scan.
// ============================================================================
// Usage:
// Requests enter on the s_ channel (s_valid/s_ready, payload s_data) and
// results leave on the m_ channel (m_valid/m_ready, payload m_data).
// Create and get-status give one result, set-status and set-timers give
// none, and a scan gives one result per fired task with last on the final
// one. Unknown request codes are taken and dropped.
// Every request reads its task entry from a single-port-read memory; those
// that change the entry write it back. A table request is taken in S_IDLE
// and executed in S_EXEC, which writes its result into the output register.
// A scan walks all MAX_TASKS entries, one entry per cycle through the memory
// read port unless it waits on a full output register, and then hands over
// the last fired task in S_FLUSH. The next request is taken as soon as the
// previous one is finished, even while its result still waits in the output
// register. When m_ready is held low, the block holds its work at the first
// point where it must hand over another result, and nothing is lost.
// Reset clears all valid bits of the table at once: every task reads as idle
// with zero times, and the create counter starts again at id 1.
// ============================================================================
`default_nettype none

module periodic_task_dispatch_table_unit #(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ptd_pkg::ptd_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ptd_pkg::ptd_out_t     m_data
);

    // Address width of the table and width of the create counter, which
    // must also hold MAX_TASKS itself to flag a full table.
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = TIME_BITS;
    // Entry layout, high to low: status, kind, start stamp, period.
    localparam int EW = 3 + 2 * TW;

    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_TASKS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TASKS - 1);
    localparam logic [7:0]    MAX_ID   = 8'(MAX_TASKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t             state_reg,      state_next;
    ptd_pkg::ptd_in_t   req_reg,        req_next;
    logic [AW-1:0]      addr_reg,       addr_next;
    logic [AW-1:0]      scan_idx_reg,   scan_idx_next;
    logic [CW-1:0]      next_index_reg, next_index_next;
    logic               pend_vld_reg,   pend_vld_next;
    ptd_pkg::ptd_out_t  pend_reg,       pend_next;
    logic               m_valid_reg,    m_valid_next;
    ptd_pkg::ptd_out_t  m_data_reg,     m_data_next;

    // Table port signals.
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          rd_vld;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // Current entry, as read from the table. An entry never written reads
    // as all zero (idle, run once, zero times).
    logic [EW-1:0] cur;
    logic [1:0]    cur_state;
    logic          cur_kind;
    logic [TW-1:0] cur_start;
    logic [TW-1:0] cur_period;

    logic [TW-1:0] now_t;
    logic [TW-1:0] start_t;
    logic [TW-1:0] period_t;
    logic [TW-1:0] elapsed;
    logic          fire;
    logic [1:0]    fire_state;
    logic          full;
    logic          id_ok;
    logic          out_free;
    logic [3:0]    acc_id_m1;
    logic [AW-1:0] acc_addr;

    ptd_table #(
        .DEPTH (MAX_TASKS),
        .AW    (AW),
        .DW    (EW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rd_vld  (rd_vld),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign cur        = rd_vld ? rd_data : '0;
    assign cur_state  = cur[EW-1 -: 2];
    assign cur_kind   = cur[2*TW];
    assign cur_start  = cur[2*TW-1 -: TW];
    assign cur_period = cur[TW-1:0];

    // Times are kept modulo 2^TIME_BITS.
    assign now_t    = TW'(req_reg.now_time);
    assign start_t  = TW'(req_reg.start_time);
    assign period_t = TW'(req_reg.period);

    // Wrapping elapsed time against the period of the entry under scan.
    assign elapsed    = now_t - cur_start;
    assign fire       = (cur_state == ptd_pkg::ST_READY) && (elapsed >= cur_period);
    assign fire_state = cur_kind ? ptd_pkg::ST_READY : ptd_pkg::ST_IDLE;

    assign full  = (next_index_reg >= MAX_CNT);
    assign id_ok = (req_reg.task_id != 4'd0) && ({4'd0, req_reg.task_id} <= MAX_ID);

    // The output register can take a new item this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // Table address of the request being accepted.
    assign acc_id_m1 = s_data.task_id - 4'd1;
    always_comb begin
        case (s_data.req_type)
            ptd_pkg::REQ_CREATE: acc_addr = next_index_reg[AW-1:0];
            ptd_pkg::REQ_SCAN:   acc_addr = '0;
            default:             acc_addr = AW'(acc_id_m1);
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        scan_idx_next   = scan_idx_reg;
        next_index_next = next_index_reg;
        pend_vld_next   = pend_vld_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        rd_en   = 1'b0;
        rd_addr = scan_idx_reg + 1'b1;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = cur;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                // Take a request and start the read of its entry at once.
                if (s_valid) begin
                    req_next      = s_data;
                    rd_en         = 1'b1;
                    rd_addr       = acc_addr;
                    addr_next     = acc_addr;
                    scan_idx_next = '0;
                    pend_vld_next = 1'b0;
                    state_next    = (s_data.req_type == ptd_pkg::REQ_SCAN) ? S_SCAN : S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (req_reg.req_type)
                    ptd_pkg::REQ_CREATE: begin
                        if (out_free) begin
                            m_valid_next        = 1'b1;
                            m_data_next.status  = ptd_pkg::ST_IDLE;
                            m_data_next.fired   = 1'b0;
                            m_data_next.last    = 1'b1;
                            if (full) begin
                                m_data_next.result_id = 4'd0;
                            end else begin
                                // The status of the entry is kept as it was.
                                m_data_next.result_id = 4'(next_index_reg + 1'b1);
                                wr_en           = 1'b1;
                                wr_data         = {cur_state, req_reg.periodic, start_t, period_t};
                                next_index_next = next_index_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ptd_pkg::REQ_SET_STATUS: begin
                        if (id_ok && (req_reg.new_status != ptd_pkg::ST_UNDEF)) begin
                            wr_en   = 1'b1;
                            wr_data = {req_reg.new_status, cur_kind,
                                       (req_reg.new_status == ptd_pkg::ST_READY) ?
                                           now_t : cur_start,
                                       cur_period};
                        end
                        state_next = S_IDLE;
                    end
                    ptd_pkg::REQ_GET_STATUS: begin
                        if (out_free) begin
                            m_valid_next          = 1'b1;
                            m_data_next.result_id = req_reg.task_id;
                            m_data_next.status    = id_ok ? cur_state : ptd_pkg::ST_UNDEF;
                            m_data_next.fired     = 1'b0;
                            m_data_next.last      = 1'b1;
                            state_next            = S_IDLE;
                        end
                    end
                    ptd_pkg::REQ_SET_TIMERS: begin
                        // A zero value leaves the stored one in place.
                        if (id_ok) begin
                            wr_en   = 1'b1;
                            wr_data = {cur_state, cur_kind,
                                       (start_t != '0) ? start_t : cur_start,
                                       (period_t != '0) ? period_t : cur_period};
                        end
                        state_next = S_IDLE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_SCAN: begin
                // A fired task is held back one step so that the final one
                // can carry last. When a second task fires while the output
                // register is still full, the scan waits on this entry.
                wr_addr = scan_idx_reg;
                if (!(fire && pend_vld_reg && !out_free)) begin
                    if (fire) begin
                        wr_en   = 1'b1;
                        wr_data = {fire_state, cur_kind, now_t, cur_period};
                        if (pend_vld_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_reg;
                        end
                        pend_vld_next      = 1'b1;
                        pend_next.result_id = 4'({1'b0, scan_idx_reg} + 1'b1);
                        pend_next.status    = fire_state;
                        pend_next.fired     = 1'b1;
                        pend_next.last      = 1'b0;
                    end
                    if (scan_idx_reg == LAST_IDX) begin
                        state_next = (pend_vld_reg || fire) ? S_FLUSH : S_IDLE;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = scan_idx_reg + 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = pend_reg;
                    m_data_next.last = 1'b1;
                    pend_vld_next    = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            next_index_reg <= '0;
            pend_vld_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            scan_idx_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            next_index_reg <= next_index_next;
            pend_vld_reg   <= pend_vld_next;
            m_valid_reg    <= m_valid_next;
            scan_idx_reg   <= scan_idx_next;
        end
        req_reg    <= req_next;
        addr_reg   <= addr_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* verif/ptd_dispatch_checker.sv */
// ============================================================================
// ptd_dispatch_checker
// Watches both channels of the dispatch table, predicts and compares results.
// ============================================================================
`default_nettype none

module ptd_dispatch_checker #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire ptd_pkg::ptd_in_t  s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire ptd_pkg::ptd_out_t m_data,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the task table.
    int          tasks_created;
    logic [1:0]  shadow_state  [MAX_TASKS];
    logic [31:0] task_stamp    [MAX_TASKS];
    logic [31:0] task_interval [MAX_TASKS];
    logic        task_repeats  [MAX_TASKS];

    ptd_pkg::ptd_out_t expected_results [$];
    int                mismatches;

    function automatic ptd_pkg::ptd_out_t result_item(logic [3:0] id, logic [1:0] st,
                                                      logic fired, logic last);
        ptd_pkg::ptd_out_t r;
        r.result_id = id;
        r.status    = st;
        r.fired     = fired;
        r.last      = last;
        return r;
    endfunction

    // Applies one accepted request to the shadow table and queues the results
    // that it must produce.
    task automatic apply_request(input ptd_pkg::ptd_in_t req);
        int                   slot;
        int                   last_hit;
        logic                 id_valid;
        logic [MAX_TASKS-1:0] due;
        logic [31:0]          elapsed;
        slot     = int'(req.task_id) - 1;
        id_valid = (req.task_id >= 1) && (req.task_id <= MAX_TASKS);
        case (req.req_type)
            ptd_pkg::REQ_CREATE: begin
                if (tasks_created >= MAX_TASKS) begin
                    expected_results.push_back(
                        result_item(4'd0, ptd_pkg::ST_IDLE, 1'b0, 1'b1));
                end else begin
                    task_stamp[tasks_created]    = req.start_time;
                    task_interval[tasks_created] = req.period;
                    task_repeats[tasks_created]  = req.periodic;
                    tasks_created++;
                    expected_results.push_back(
                        result_item(4'(tasks_created), ptd_pkg::ST_IDLE, 1'b0, 1'b1));
                end
            end
            ptd_pkg::REQ_SET_STATUS: begin
                if (id_valid && req.new_status != ptd_pkg::ST_UNDEF) begin
                    shadow_state[slot] = req.new_status;
                    if (req.new_status == ptd_pkg::ST_READY)
                        task_stamp[slot] = req.now_time;
                end
            end
            ptd_pkg::REQ_GET_STATUS: begin
                if (id_valid) begin
                    expected_results.push_back(
                        result_item(req.task_id, shadow_state[slot], 1'b0, 1'b1));
                end else begin
                    expected_results.push_back(
                        result_item(req.task_id, ptd_pkg::ST_UNDEF, 1'b0, 1'b1));
                end
            end
            ptd_pkg::REQ_SET_TIMERS: begin
                if (id_valid) begin
                    if (req.start_time != 0)
                        task_stamp[slot] = req.start_time;
                    if (req.period != 0)
                        task_interval[slot] = req.period;
                end
            end
            ptd_pkg::REQ_SCAN: begin
                // The firing test of each entry depends only on that entry, so
                // the due set is found first to know which hit carries last.
                last_hit = -1;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    elapsed = req.now_time - task_stamp[i];
                    due[i]  = (shadow_state[i] == ptd_pkg::ST_READY) &&
                              (elapsed >= task_interval[i]);
                    if (due[i])
                        last_hit = i;
                end
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (due[i]) begin
                        task_stamp[i]   = req.now_time;
                        shadow_state[i] = task_repeats[i] ? ptd_pkg::ST_READY
                                                          : ptd_pkg::ST_IDLE;
                        expected_results.push_back(
                            result_item(4'(i + 1), shadow_state[i], 1'b1, i == last_hit));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        ptd_pkg::ptd_out_t want;
        if (!aresetn) begin
            tasks_created = 0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                shadow_state[i]  = ptd_pkg::ST_IDLE;
                task_stamp[i]    = '0;
                task_interval[i] = '0;
                task_repeats[i]  = 1'b0;
            end
            expected_results.delete();
            mismatches = 0;
        end else begin
            // A result always trails its request, so results are matched
            // before the request taken at the same edge is predicted.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_id %0d status %0d fired %0d last %0d",
                           m_data.result_id, m_data.status, m_data.fired, m_data.last);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_id", want.result_id, m_data.result_id);
                    check_field("status", want.status, m_data.status);
                    check_field("fired", want.fired, m_data.fired);
                    check_field("last", want.last, m_data.last);
                end
            end
            if (s_valid && s_ready)
                apply_request(s_data);
        end
        fail_count  <= mismatches;
        outstanding <= expected_results.size();
    end

endmodule

`default_nettype wire

/* verif/periodic_task_dispatch_table_unit_tb.sv */
// ============================================================================
// periodic_task_dispatch_table_unit_tb
// Drives requests into the dispatch table and judges the run.
// ============================================================================
// A directed opening fills the table, probes bad ids, ignored status codes,
// zero timer values, wrapping elapsed times and unknown request codes. Random
// phases then run coherent request traffic against a slowly advancing time
// base, under changing sender gaps and receiver stalls. A side checker
// predicts every result and counts mismatches.
// ============================================================================
`default_nettype none

module periodic_task_dispatch_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_TASKS       = 8;
    localparam int         CLK_HALF        = 4;
    localparam int         RESET_CYCLES    = 12;
    // Settle wait after the results are in, to cover any work in flight.
    localparam int         SETTLE_CYCLES   = 2 * MAX_TASKS;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_LIMIT     = 20000;
    localparam int         PHASE_ITEMS     = 33;
    localparam int         RUN_LIMIT_NS    = 4_000_000;
    // Highest request code; codes above REQ_SCAN are unknown to the block.
    localparam logic [2:0] REQ_CODE_MAX    = 3'd7;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ptd_pkg::ptd_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ptd_pkg::ptd_out_t m_data;

    int          fail_count;
    int          outstanding;

    // Idling controls, shared with the receiver process.
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          hold_off_req  = 0;

    // Time base that random requests are stamped from, advanced by each one.
    logic [31:0] sim_now;

    periodic_task_dispatch_table_unit #(
        .MAX_TASKS(MAX_TASKS),
        .TIME_BITS(32)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    ptd_dispatch_checker #(
        .MAX_TASKS(MAX_TASKS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT_NS;
        $error("run limit reached with %0d results outstanding", outstanding);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested. The
    // hold-off is counted here so that the sender keeps offering items
    // meanwhile and the block has to back up into its input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req != 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    function automatic ptd_pkg::ptd_in_t make_req(logic [2:0] req, logic [3:0] id,
                                                  logic [31:0] start, logic [31:0] period,
                                                  logic periodic, logic [1:0] status,
                                                  logic [31:0] now);
        ptd_pkg::ptd_in_t r;
        r.req_type   = req;
        r.task_id    = id;
        r.start_time = start;
        r.period     = period;
        r.periodic   = periodic;
        r.new_status = status;
        r.now_time   = now;
        return r;
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid is left
    // high, so a following item with no gap goes out back to back; a gap
    // lowers valid first.
    task automatic offer(input ptd_pkg::ptd_in_t item);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending and waits for every predicted result, then lets any work
    // that produces no result finish.
    task automatic drain();
        int guard;
        s_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (outstanding != 0 && guard < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Builds one random request. Most requests address real tasks with times
    // close to the running time base, so that scans really fire; the rest is
    // bad ids, odd status codes, far-off times and unknown request codes.
    task automatic random_request(output ptd_pkg::ptd_in_t req);
        int pick;
        // Fields that the request does not use still carry random bits.
        req.req_type   = 3'($urandom);
        req.task_id    = 4'($urandom);
        req.start_time = $urandom;
        req.period     = $urandom;
        req.periodic   = 1'($urandom);
        req.new_status = 2'($urandom);
        req.now_time   = $urandom;

        sim_now = sim_now + 32'($urandom_range(0, 40));
        pick    = $urandom_range(0, 99);
        if (pick < 6) begin
            req.req_type = ptd_pkg::REQ_CREATE;
            if ($urandom_range(0, 3) != 0)
                req.period = 32'($urandom_range(0, 150));
        end else if (pick < 28) begin
            req.req_type = ptd_pkg::REQ_SET_STATUS;
            if ($urandom_range(0, 9) != 0)
                req.task_id = 4'($urandom_range(1, MAX_TASKS));
            if ($urandom_range(0, 3) != 0)
                req.new_status = ptd_pkg::ST_READY;
            req.now_time = sim_now;
        end else if (pick < 42) begin
            req.req_type = ptd_pkg::REQ_GET_STATUS;
            if ($urandom_range(0, 9) != 0)
                req.task_id = 4'($urandom_range(1, MAX_TASKS));
        end else if (pick < 56) begin
            req.req_type = ptd_pkg::REQ_SET_TIMERS;
            if ($urandom_range(0, 9) != 0)
                req.task_id = 4'($urandom_range(1, MAX_TASKS));
            // Zero keeps the stored value, so it is chosen often.
            if ($urandom_range(0, 2) == 0)
                req.start_time = '0;
            else if ($urandom_range(0, 9) != 0)
                req.start_time = sim_now - 32'($urandom_range(0, 100));
            if ($urandom_range(0, 2) == 0)
                req.period = '0;
            else if ($urandom_range(0, 9) != 0)
                req.period = 32'($urandom_range(1, 150));
        end else if (pick < 94) begin
            req.req_type = ptd_pkg::REQ_SCAN;
            if ($urandom_range(0, 19) != 0)
                req.now_time = sim_now;
        end else begin
            req.req_type = 3'($urandom_range(ptd_pkg::REQ_SCAN + 1, REQ_CODE_MAX));
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        ptd_pkg::ptd_in_t item;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) begin
            random_request(item);
            offer(item);
        end
        drain();
    endtask

    initial begin : stimulus
        sim_now = 32'hFFFF_F000;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Status queries on bad ids and on an entry that was never created.
        offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'd0, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, '0));
        offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'hF, '1, '1, 1'b1,
                       ptd_pkg::ST_UNDEF, '1));
        offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'd1, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, '0));

        // Fill the table, alternating periodic and run-once tasks. The second
        // task gets the largest start and period, the first a period of zero.
        for (int i = 0; i < MAX_TASKS; i++) begin
            offer(make_req(ptd_pkg::REQ_CREATE, 4'd0,
                           (i == 1) ? 32'hFFFF_FFFF : 32'(i * 10),
                           (i == 1) ? 32'hFFFF_FFFF : 32'(i * 20),
                           (i % 2) == 0, ptd_pkg::ST_IDLE, '0));
        end
        // One more create finds the table full.
        offer(make_req(ptd_pkg::REQ_CREATE, 4'd0, 32'd7, 32'd7, 1'b1,
                       ptd_pkg::ST_IDLE, '0));

        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd1, '0, '0, 1'b0,
                       ptd_pkg::ST_READY, 32'd5));
        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd2, '0, '0, 1'b0,
                       ptd_pkg::ST_READY, 32'hFFFF_FFF0));
        // A status code of three is ignored, and so is a bad id.
        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd3, '0, '0, 1'b0,
                       ptd_pkg::ST_UNDEF, 32'd1));
        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd0, '0, '0, 1'b0,
                       ptd_pkg::ST_READY, 32'd1));
        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd4, '0, '0, 1'b0,
                       ptd_pkg::ST_RUNNING, 32'd1));

        // Zero timer values keep the old ones; a bad id changes nothing.
        offer(make_req(ptd_pkg::REQ_SET_TIMERS, 4'd2, '0, '0, 1'b1,
                       ptd_pkg::ST_IDLE, '0));
        offer(make_req(ptd_pkg::REQ_SET_TIMERS, 4'd3, 32'd10, 32'd20, 1'b0,
                       ptd_pkg::ST_IDLE, '0));
        offer(make_req(ptd_pkg::REQ_SET_TIMERS, 4'd9, 32'd1, 32'd1, 1'b0,
                       ptd_pkg::ST_IDLE, '0));
        offer(make_req(ptd_pkg::REQ_SET_STATUS, 4'd3, '0, '0, 1'b0,
                       ptd_pkg::ST_READY, 32'd15));
        offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'd4, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, '0));

        // The first scan fires tasks one and three; the second one wraps the
        // elapsed time of task two to exactly its full-range period.
        offer(make_req(ptd_pkg::REQ_SCAN, 4'd0, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, 32'd40));
        offer(make_req(ptd_pkg::REQ_SCAN, 4'd0, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, 32'hFFFF_FFEF));
        offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'd2, '0, '0, 1'b0,
                       ptd_pkg::ST_IDLE, '0));

        // Unknown request codes are dropped.
        offer(make_req(ptd_pkg::REQ_SCAN + 3'd1, 4'd1, '1, '1, 1'b1,
                       ptd_pkg::ST_READY, '1));
        offer(make_req(REQ_CODE_MAX, 4'd2, '1, '1, 1'b1, ptd_pkg::ST_READY, '1));
        drain();

        run_phase(0, 0);

        // Long receiver hold-off while queries keep coming, so the output
        // register fills and the input has to stall.
        hold_off_req = HOLD_OFF_CYCLES;
        for (int i = 0; i < 12; i++)
            offer(make_req(ptd_pkg::REQ_GET_STATUS, 4'((i % MAX_TASKS) + 1), '0, '0,
                           1'b0, ptd_pkg::ST_IDLE, '0));
        drain();

        run_phase(75, 0);
        run_phase(0, 75);
        run_phase(7, 7);

        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/ptd_pkg.sv
sv/ptd_table.sv
sv/periodic_task_dispatch_table_unit.sv
verif/ptd_dispatch_checker.sv
verif/periodic_task_dispatch_table_unit_tb.sv
